// File: src/mesh_signed_volume_macros.svh
// ---------------------------------------------------------------------------
// mesh_signed_volume assertion macros
// Clocked assertion helpers used by the controller RTL of the volume block.
// ---------------------------------------------------------------------------
`ifndef MESH_SIGNED_VOLUME_MACROS_SVH
`define MESH_SIGNED_VOLUME_MACROS_SVH

`ifndef NO_ASSERTIONS

`define MSV_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("mesh_signed_volume assertion failed");

`define MSV_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("mesh_signed_volume forbidden condition");

`else

`define MSV_ASSERT(label, clk, rst, prop)

`define MSV_NEVER(label, clk, rst, expr)

`endif

`endif

// File: src/msv_pkg.sv
// ---------------------------------------------------------------------------
// msv_pkg
// Widths, sequencer steps, FSM states and command types of the volume block.
// ---------------------------------------------------------------------------
package msv_pkg;

  localparam int ID_W        = 16;
  localparam int COORD_W     = 20;
  localparam int VOL_W       = 64;
  localparam int OPND_W      = COORD_W + 1;
  localparam int PROD_W      = 2 * OPND_W;
  localparam int CROSS_W     = 2 * COORD_W + 1;
  localparam int LO_W        = COORD_W;
  localparam int HI_W        = CROSS_W - LO_W;
  localparam int DET_W       = 3 * COORD_W + 2;
  localparam int MUL_STEPS   = 12;
  localparam int DIG_W       = 16;
  localparam int DIV_STEPS   = VOL_W / DIG_W;
  localparam int CNT_W       = 6;
  localparam int STEP_W      = 4;
  localparam int REM_W       = 3;
  localparam int PART_W      = REM_W + DIG_W;
  localparam int RECIP_W     = 20;
  localparam int RECIP_SHIFT = 22;
  localparam int SCALED_W    = PART_W + RECIP_W;
  // ceil(2^22 / 6): exact digit for any partial dividend below 6 * 2^16
  localparam logic [RECIP_W-1:0] RECIP = 20'd699051;

  typedef enum logic [STEP_W-1:0] {
    STEP_BY_CZ = 4'd0,
    STEP_BZ_CY = 4'd1,
    STEP_BZ_CX = 4'd2,
    STEP_BX_CZ = 4'd3,
    STEP_BX_CY = 4'd4,
    STEP_BY_CX = 4'd5,
    STEP_AX_HI = 4'd6,
    STEP_AX_LO = 4'd7,
    STEP_AY_HI = 4'd8,
    STEP_AY_LO = 4'd9,
    STEP_AZ_HI = 4'd10,
    STEP_AZ_LO = 4'd11
  } msv_step_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_PREP,
    ST_DIV,
    ST_EMIT
  } msv_state_t;

  typedef struct packed {
    logic      load_in;
    logic      mul_en;
    msv_step_t mul_step;
    logic      cons_en;
    msv_step_t cons_step;
    logic      acc_en;
    logic      div_start;
    logic      div_en;
    logic      out_load;
  } msv_cmd_t;

  typedef struct packed {
    logic last;
  } msv_stat_t;

endpackage

// File: src/msv_datapath.sv
// ---------------------------------------------------------------------------
// msv_datapath
// Operand registers, shared multiplier, cross and dot product, saturating
// accumulator, divide-by-six unit and result registers.
// ---------------------------------------------------------------------------
module msv_datapath
  import msv_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  msv_cmd_t                  cmd,
  output msv_stat_t                 stat,
  input  logic [ID_W-1:0]           cell_id,
  input  logic signed [COORD_W-1:0] a_x,
  input  logic signed [COORD_W-1:0] a_y,
  input  logic signed [COORD_W-1:0] a_z,
  input  logic signed [COORD_W-1:0] b_x,
  input  logic signed [COORD_W-1:0] b_y,
  input  logic signed [COORD_W-1:0] b_z,
  input  logic signed [COORD_W-1:0] c_x,
  input  logic signed [COORD_W-1:0] c_y,
  input  logic signed [COORD_W-1:0] c_z,
  input  logic                      last_triangle,
  output logic [ID_W-1:0]           out_cell_id,
  output logic signed [VOL_W-1:0]   volume,
  output logic                      saturated
);

  logic [ID_W-1:0]            id_q;
  logic                       last_q;
  logic signed [COORD_W-1:0]  ax, ay, az, bx, by, bz, cx, cy, cz;
  logic signed [OPND_W-1:0]   op_l, op_r;
  logic signed [PROD_W-1:0]   prod, tmp;
  logic signed [CROSS_W-1:0]  cr_x, cr_y, cr_z, cr_new;
  logic signed [DET_W-1:0]    det, prod_ext, prod_hi;
  logic signed [VOL_W-1:0]    sum, det_ext;
  logic signed [VOL_W:0]      sum_wide;
  logic                       clip;
  logic                       neg;
  logic [VOL_W-1:0]           quo;
  logic [REM_W-1:0]           rem;
  logic [PART_W-1:0]          part, part_rem;
  logic [SCALED_W-1:0]        part_scaled;
  logic [DIG_W-1:0]           digit;

  assign stat.last = last_q;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      id_q   <= cell_id;
      last_q <= last_triangle;
      ax <= a_x; ay <= a_y; az <= a_z;
      bx <= b_x; by <= b_y; bz <= b_z;
      cx <= c_x; cy <= c_y; cz <= c_z;
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    case (cmd.mul_step)
      STEP_BY_CZ: begin op_l = OPND_W'(by); op_r = OPND_W'(cz); end
      STEP_BZ_CY: begin op_l = OPND_W'(bz); op_r = OPND_W'(cy); end
      STEP_BZ_CX: begin op_l = OPND_W'(bz); op_r = OPND_W'(cx); end
      STEP_BX_CZ: begin op_l = OPND_W'(bx); op_r = OPND_W'(cz); end
      STEP_BX_CY: begin op_l = OPND_W'(bx); op_r = OPND_W'(cy); end
      STEP_BY_CX: begin op_l = OPND_W'(by); op_r = OPND_W'(cx); end
      STEP_AX_HI: begin op_l = OPND_W'(ax); op_r = OPND_W'(cr_x[CROSS_W-1:LO_W]); end
      STEP_AX_LO: begin op_l = OPND_W'(ax); op_r = {1'b0, cr_x[LO_W-1:0]}; end
      STEP_AY_HI: begin op_l = OPND_W'(ay); op_r = OPND_W'(cr_y[CROSS_W-1:LO_W]); end
      STEP_AY_LO: begin op_l = OPND_W'(ay); op_r = {1'b0, cr_y[LO_W-1:0]}; end
      STEP_AZ_HI: begin op_l = OPND_W'(az); op_r = OPND_W'(cr_z[CROSS_W-1:LO_W]); end
      STEP_AZ_LO: begin op_l = OPND_W'(az); op_r = {1'b0, cr_z[LO_W-1:0]}; end
      default:    begin op_l = '0; op_r = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= PROD_W'(op_l) * PROD_W'(op_r);
    end
  end

  assign cr_new   = CROSS_W'(tmp - prod);
  assign prod_ext = DET_W'(prod);
  assign prod_hi  = prod_ext <<< LO_W;

  // consume the previous product
  always_ff @(posedge clk) begin
    if (cmd.cons_en) begin
      case (cmd.cons_step)
        STEP_BY_CZ: tmp  <= prod;
        STEP_BZ_CY: cr_x <= cr_new;
        STEP_BZ_CX: tmp  <= prod;
        STEP_BX_CZ: cr_y <= cr_new;
        STEP_BX_CY: tmp  <= prod;
        STEP_BY_CX: cr_z <= cr_new;
        STEP_AX_HI: det  <= prod_hi;
        STEP_AX_LO: det  <= det + prod_ext;
        STEP_AY_HI: det  <= det + prod_hi;
        STEP_AY_LO: det  <= det + prod_ext;
        STEP_AZ_HI: det  <= det + prod_hi;
        STEP_AZ_LO: det  <= det + prod_ext;
        default:    tmp  <= tmp;
      endcase
    end
  end

  assign det_ext  = VOL_W'(det);
  assign sum_wide = {sum[VOL_W-1], sum} + {det_ext[VOL_W-1], det_ext};

  always_ff @(posedge clk) begin
    if (rst) begin
      sum  <= '0;
      clip <= 1'b0;
    end else if (cmd.acc_en) begin
      if (sum_wide[VOL_W] != sum_wide[VOL_W-1]) begin
        sum  <= sum_wide[VOL_W] ? {1'b1, {(VOL_W-1){1'b0}}} : {1'b0, {(VOL_W-1){1'b1}}};
        clip <= 1'b1;
      end else begin
        sum <= sum_wide[VOL_W-1:0];
      end
    end else if (cmd.out_load) begin
      sum  <= '0;
      clip <= 1'b0;
    end
  end

  // divide magnitude by six, sixteen quotient bits a cycle
  assign part        = {rem, quo[VOL_W-1 -: DIG_W]};
  assign part_scaled = {{RECIP_W{1'b0}}, part} * {{PART_W{1'b0}}, RECIP};
  assign digit       = part_scaled[RECIP_SHIFT +: DIG_W];
  assign part_rem    = part - ({1'b0, digit, 2'b00} + {2'b00, digit, 1'b0});

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      neg <= sum[VOL_W-1];
      quo <= sum[VOL_W-1] ? VOL_W'(-sum) : VOL_W'(sum);
      rem <= '0;
    end else if (cmd.div_en) begin
      rem <= part_rem[REM_W-1:0];
      quo <= {quo[VOL_W-DIG_W-1:0], digit};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_cell_id <= id_q;
      volume      <= neg ? -$signed(quo) : $signed(quo);
      saturated   <= clip;
    end
  end

endmodule

// File: src/msv_ctrl.sv
// ---------------------------------------------------------------------------
// msv_ctrl
// Sequencer for the volume block: multiply steps, accumulate, divide and
// result hand-off.
// ---------------------------------------------------------------------------
`include "mesh_signed_volume_macros.svh"

module msv_ctrl
  import msv_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      tri_valid,
  output logic      tri_ready,
  output logic      vol_valid,
  input  logic      vol_ready,
  input  msv_stat_t stat,
  output msv_cmd_t  cmd
);

  msv_state_t       state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             out_free;

  assign out_free = !vol_valid || vol_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      vol_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (cmd.out_load) begin
        vol_valid <= 1'b1;
      end else if (vol_ready) begin
        vol_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    case (state)
      ST_IDLE: begin
        cnt_next = '0;
        if (tri_valid) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        if (cnt == CNT_W'(MUL_STEPS)) begin
          state_next = ST_ACC;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_ACC: begin
        state_next = stat.last ? ST_PREP : ST_IDLE;
      end
      ST_PREP: begin
        state_next = ST_DIV;
        cnt_next   = '0;
      end
      ST_DIV: begin
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          state_next = ST_EMIT;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
        cnt_next   = '0;
      end
    endcase
  end

  always_comb begin
    tri_ready     = 1'b0;
    cmd           = '0;
    cmd.mul_step  = msv_step_t'(cnt[STEP_W-1:0]);
    cmd.cons_step = msv_step_t'(STEP_W'(cnt[STEP_W-1:0] - 1'b1));
    case (state)
      ST_IDLE: begin
        tri_ready   = 1'b1;
        cmd.load_in = tri_valid;
      end
      ST_MUL: begin
        cmd.mul_en  = cnt < CNT_W'(MUL_STEPS);
        cmd.cons_en = cnt != '0;
      end
      ST_ACC:  cmd.acc_en    = 1'b1;
      ST_PREP: cmd.div_start = 1'b1;
      ST_DIV:  cmd.div_en    = 1'b1;
      ST_EMIT: cmd.out_load  = out_free;
      default: tri_ready     = 1'b0;
    endcase
  end

  `MSV_ASSERT(a_load_free, clk, rst, cmd.out_load |-> (!vol_valid || vol_ready))
  `MSV_ASSERT(a_accept_mul, clk, rst, (tri_valid && tri_ready) |=> (state == ST_MUL && cnt == '0))
  `MSV_ASSERT(a_rise_load, clk, rst, $rose(vol_valid) |-> $past(cmd.out_load))
  `MSV_NEVER(a_mul_range, clk, rst, state == ST_MUL && cnt > CNT_W'(MUL_STEPS))

endmodule

// File: src/mesh_signed_volume.sv
// ---------------------------------------------------------------------------
// mesh_signed_volume
// Signed volume of a closed triangle mesh per cell: accumulates a.(b x c)
// per triangle, divides by six on the last one and reports it.
// ---------------------------------------------------------------------------
//  channel   handshake              payload
//  triangle  tri_valid/tri_ready    cell_id, a_*, b_*, c_*, last_triangle
//  volume    vol_valid/vol_ready    out_cell_id, volume, saturated
//
//  tri_ready stays low after acceptance while a triangle takes twelve
//  products through one shared 21 x 21 multiplier, a drain step and then
//  the saturating add.
//  A last triangle adds setup, a four-step divide by six and emit.
//  The next triangle is taken while a finished volume waits on vol_ready.
//  A new volume waits in the emit state until the result register is free.
//  Reset clears the accumulator, the clip flag and vol_valid.
// ---------------------------------------------------------------------------
module mesh_signed_volume
  import msv_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      tri_valid,
  output logic                      tri_ready,
  input  logic [ID_W-1:0]           cell_id,
  input  logic signed [COORD_W-1:0] a_x,
  input  logic signed [COORD_W-1:0] a_y,
  input  logic signed [COORD_W-1:0] a_z,
  input  logic signed [COORD_W-1:0] b_x,
  input  logic signed [COORD_W-1:0] b_y,
  input  logic signed [COORD_W-1:0] b_z,
  input  logic signed [COORD_W-1:0] c_x,
  input  logic signed [COORD_W-1:0] c_y,
  input  logic signed [COORD_W-1:0] c_z,
  input  logic                      last_triangle,
  output logic                      vol_valid,
  input  logic                      vol_ready,
  output logic [ID_W-1:0]           out_cell_id,
  output logic signed [VOL_W-1:0]   volume,
  output logic                      saturated
);

  msv_cmd_t  cmd;
  msv_stat_t stat;

  msv_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .tri_valid (tri_valid),
    .tri_ready (tri_ready),
    .vol_valid (vol_valid),
    .vol_ready (vol_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  msv_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cell_id       (cell_id),
    .a_x           (a_x),
    .a_y           (a_y),
    .a_z           (a_z),
    .b_x           (b_x),
    .b_y           (b_y),
    .b_z           (b_z),
    .c_x           (c_x),
    .c_y           (c_y),
    .c_z           (c_z),
    .last_triangle (last_triangle),
    .out_cell_id   (out_cell_id),
    .volume        (volume),
    .saturated     (saturated)
  );

endmodule

// File: dv/mesh_signed_volume_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Volume checker
// Watches the triangle and volume channels of mesh_signed_volume, keeps its
// own accumulator of a.(b x c) with clipping, and compares every volume item
// with the oldest volume still due.
// ----------------------------------------------------------------------------
module mesh_signed_volume_checker
  import msv_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      tri_valid,
  input  logic                      tri_ready,
  input  logic [ID_W-1:0]           cell_id,
  input  logic signed [COORD_W-1:0] a_x,
  input  logic signed [COORD_W-1:0] a_y,
  input  logic signed [COORD_W-1:0] a_z,
  input  logic signed [COORD_W-1:0] b_x,
  input  logic signed [COORD_W-1:0] b_y,
  input  logic signed [COORD_W-1:0] b_z,
  input  logic signed [COORD_W-1:0] c_x,
  input  logic signed [COORD_W-1:0] c_y,
  input  logic signed [COORD_W-1:0] c_z,
  input  logic                      last_triangle,
  input  logic                      vol_valid,
  input  logic                      vol_ready,
  input  logic [ID_W-1:0]           out_cell_id,
  input  logic signed [VOL_W-1:0]   volume,
  input  logic                      saturated,
  output int                        fail_count,
  output int                        pending
);

  typedef struct packed {
    logic [ID_W-1:0]         id;
    logic signed [VOL_W-1:0] vol;
    logic                    sat;
  } cell_volume_t;

  cell_volume_t            volumes_due[$];
  logic signed [VOL_W-1:0] volume_acc;
  logic                    clipped;

  initial begin
    fail_count = 0;
    pending    = 0;
    volume_acc = '0;
    clipped    = 1'b0;
  end

  always @(posedge clk) begin
    cell_volume_t            want;
    longint                  ax, ay, az, bx, by, bz, cx, cy, cz;
    longint                  det;
    logic signed [VOL_W:0]   sum;
    if (rst) begin
      volume_acc = '0;
      clipped    = 1'b0;
      volumes_due.delete();
    end else begin
      // check the outgoing item first: it can never belong to this edge's triangle
      if (vol_valid && vol_ready) begin
        if (volumes_due.size() == 0) begin
          $error("volume item with none due: cell %0h volume %0d", out_cell_id, volume);
          fail_count++;
        end else begin
          want = volumes_due.pop_front();
          if (out_cell_id !== want.id) begin
            $error("out_cell_id mismatch: expected %0h, got %0h", want.id, out_cell_id);
            fail_count++;
          end
          if (volume !== want.vol) begin
            $error("volume mismatch: expected %0d, got %0d", want.vol, volume);
            fail_count++;
          end
          if (saturated !== want.sat) begin
            $error("saturated mismatch: expected %0b, got %0b", want.sat, saturated);
            fail_count++;
          end
        end
      end
      if (tri_valid && tri_ready) begin
        ax = a_x; ay = a_y; az = a_z;
        bx = b_x; by = b_y; bz = b_z;
        cx = c_x; cy = c_y; cz = c_z;
        det = ax * (by * cz - bz * cy) + ay * (bz * cx - bx * cz)
            + az * (bx * cy - by * cx);
        sum = $signed({volume_acc[VOL_W-1], volume_acc}) + $signed({det[63], det});
        if (sum[VOL_W] != sum[VOL_W-1]) begin
          volume_acc = sum[VOL_W] ? {1'b1, {(VOL_W-1){1'b0}}} : {1'b0, {(VOL_W-1){1'b1}}};
          clipped    = 1'b1;
        end else begin
          volume_acc = sum[VOL_W-1:0];
        end
        if (last_triangle) begin
          want.id  = cell_id;
          want.vol = volume_acc / 64'sd6;
          want.sat = clipped;
          volumes_due.insert(volumes_due.size(), want);
          volume_acc = '0;
          clipped    = 1'b0;
        end
      end
    end
    pending = volumes_due.size();
  end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mesh_signed_volume testbench
// Streams triangle meshes, clipping cells and mixed ids into
// the block with random gaps and back-pressure; the checker predicts each
// cell volume and compares.
// ----------------------------------------------------------------------------
module testbench;
  import msv_pkg::*;

  localparam logic [COORD_W-1:0] CMAX  = 20'h7FFFF;
  localparam logic [COORD_W-1:0] CMIN  = 20'h80000;
  localparam logic [COORD_W-1:0] CNEG  = 20'h80001;
  localparam logic [COORD_W-1:0] UNIT  = 20'h00400;
  localparam logic [COORD_W-1:0] ZERO  = 20'h00000;
  localparam int                 IDLE_LIMIT = 5000;

  typedef enum int {MODE_FULL, MODE_SMALL, MODE_EXTREME, MODE_BIG} coord_mode_t;

  typedef struct packed {
    logic [ID_W-1:0]              id;
    logic [8:0][COORD_W-1:0]      v;   // v[8] = a_x ... v[0] = c_z
    logic                         last;
  } facet_t;

  logic                      clk;
  logic                      rst;
  logic                      tri_valid;
  logic                      tri_ready;
  logic [ID_W-1:0]           cell_id;
  logic signed [COORD_W-1:0] a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z;
  logic                      last_triangle;
  logic                      vol_valid;
  logic                      vol_ready;
  logic [ID_W-1:0]           out_cell_id;
  logic signed [VOL_W-1:0]   volume;
  logic                      saturated;
  int                        fail_count;
  int                        pending;
  bit                        hold_results;
  int                        idle_cycles;

  mesh_signed_volume dut (.*);

  mesh_signed_volume_checker chk (.*);

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst || (tri_valid && tri_ready) || (vol_valid && vol_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    if (r < 98) return $urandom_range(5, 20);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic [COORD_W-1:0] pick_coord(coord_mode_t mode);
    logic [31:0] r;
    r = $urandom();
    case (mode)
      MODE_SMALL: return COORD_W'($signed(r[11:0]));
      MODE_EXTREME: begin
        case (r[2:0])
          3'd0: return CMAX;
          3'd1: return CMIN;
          3'd2: return ZERO;
          3'd3: return '1;
          3'd4: return 20'd1;
          3'd5: return CNEG;
          default: return r[31:12];
        endcase
      end
      default: return r[COORD_W-1:0];
    endcase
  endfunction

  // determinant +-4 * CMAX^3, the largest a triangle of +-CMAX coordinates can give
  function automatic logic [8:0][COORD_W-1:0] big_coords(bit negative);
    if (negative) return {CMAX, CMAX, CMAX, CMAX, CMAX, CNEG, CMAX, CNEG, CMAX};
    return {CMAX, CMAX, CMAX, CMAX, CNEG, CMAX, CMAX, CMAX, CNEG};
  endfunction

  task automatic offer_facet(input facet_t f, input int gap);
    @(negedge clk);
    cell_id       <= f.id;
    a_x <= f.v[8]; a_y <= f.v[7]; a_z <= f.v[6];
    b_x <= f.v[5]; b_y <= f.v[4]; b_z <= f.v[3];
    c_x <= f.v[2]; c_y <= f.v[1]; c_z <= f.v[0];
    last_triangle <= f.last;
    tri_valid     <= 1'b1;
    do @(posedge clk); while (!tri_ready);
    if (gap > 0) begin
      @(negedge clk);
      tri_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // result side: random ready pattern, plus a long hold-off on request
  initial begin : result_sink
    int left;
    int r;
    bit hold_done;
    vol_ready = 1'b0;
    left      = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_results && !hold_done) begin
        hold_done = 1'b1;
        vol_ready <= 1'b0;
        left = 600;
      end else if (left == 0) begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          vol_ready <= 1'b1;
          left = $urandom_range(1, 16);
        end else if (r < 92) begin
          vol_ready <= 1'b0;
          left = $urandom_range(1, 4);
        end else if (r < 98) begin
          vol_ready <= 1'b0;
          left = $urandom_range(10, 40);
        end else begin
          vol_ready <= 1'b1;
          left = $urandom_range(100, 200);
        end
      end else begin
        left--;
      end
    end
  end

  initial begin : stimulus
    facet_t      f;
    coord_mode_t mode;
    int          n_sent;
    int          len;
    int          kind;
    bit          neg;
    bit          mixed;
    bit          held;
    rst           = 1'b1;
    tri_valid     = 1'b0;
    cell_id       = '0;
    {a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z} = '0;
    last_triangle = 1'b0;
    hold_results  = 1'b0;
    n_sent        = 0;
    held          = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // degenerate, unit cube corner, inverted, all minimum, axis extremes
    f = '{16'h0000, '0, 1'b1};
    offer_facet(f, sender_gap());
    f = '{16'hFFFF, {UNIT, ZERO, ZERO, ZERO, UNIT, ZERO, ZERO, ZERO, UNIT}, 1'b1};
    offer_facet(f, sender_gap());
    f = '{16'h8001, {UNIT, ZERO, ZERO, ZERO, ZERO, UNIT, ZERO, UNIT, ZERO}, 1'b1};
    offer_facet(f, sender_gap());
    f = '{16'h1234, {9{CMIN}}, 1'b1};
    offer_facet(f, sender_gap());
    f = '{16'h00FF, {CMIN, ZERO, ZERO, ZERO, CMIN, ZERO, ZERO, ZERO, CMIN}, 1'b1};
    offer_facet(f, sender_gap());
    f = '{16'h7FFF, {CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMAX, CMIN}, 1'b1};
    offer_facet(f, sender_gap());
    // mixed ids: only the last one is reported
    for (int i = 0; i < 3; i++) begin
      f.id   = ID_W'(i + 1);
      for (int k = 0; k < 9; k++) f.v[k] = pick_coord(MODE_FULL);
      f.last = (i == 2);
      offer_facet(f, 0);
    end
    // clip the accumulator high
    for (int i = 0; i < 17; i++) begin
      f = '{16'hA5A5, big_coords(1'b0), i == 16};
      offer_facet(f, sender_gap());
    end
    @(negedge clk);
    tri_valid <= 1'b0;
    wait (pending == 0);

    while (n_sent < 600) begin
      if (!held && n_sent >= 300) begin
        held = 1'b1;
        hold_results = 1'b1;
        for (int i = 0; i < 10; i++) begin
          f.id = ID_W'($urandom());
          for (int k = 0; k < 9; k++) f.v[k] = pick_coord(MODE_FULL);
          f.last = 1'b1;
          offer_facet(f, 0);
          n_sent++;
        end
        @(negedge clk);
        tri_valid <= 1'b0;
        wait (pending == 0);
      end
      kind  = $urandom_range(0, 99);
      neg   = $urandom_range(0, 1);
      mixed = ($urandom_range(0, 4) == 0);
      if (kind < 6) begin
        mode = MODE_BIG;
        len  = $urandom_range(17, 22);
      end else if (kind < 70) begin
        mode = MODE_FULL;
        len  = $urandom_range(1, 6);
      end else if (kind < 85) begin
        mode = MODE_SMALL;
        len  = $urandom_range(1, 4);
      end else begin
        mode = MODE_EXTREME;
        len  = $urandom_range(1, 4);
      end
      f.id = ID_W'($urandom());
      for (int i = 0; i < len; i++) begin
        if (mixed) f.id = ID_W'($urandom());
        if (mode == MODE_BIG && $urandom_range(0, 5) != 0) begin
          f.v = big_coords(neg);
        end else begin
          for (int k = 0; k < 9; k++) f.v[k] = pick_coord(mode == MODE_BIG ? MODE_FULL : mode);
        end
        f.last = (i == len - 1);
        offer_facet(f, sender_gap());
        n_sent++;
      end
    end

    @(negedge clk);
    tri_valid <= 1'b0;
    wait (pending == 0);
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
